// ===== hw/rtl/vector_text_stroke_generator_core_macros.svh =====
// Assertion macros used by the stroke generator checker.
`ifndef VECTOR_TEXT_STROKE_GENERATOR_CORE_MACROS_SVH
`define VECTOR_TEXT_STROKE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VTSG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VTSG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vtsg_pkg.sv =====
// Shared types, constants and the character map of the stroke generator.
`default_nettype none

package vtsg_pkg;

  localparam int GLYPH_COUNT_DEF = 64;
  localparam int MAX_STROKES_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int LINE_W          = 16;
  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 32;

  // Action codes of an input beat
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SCALE_X      = 2'd0;
  localparam logic [1:0] REG_SCALE_Y      = 2'd1;
  localparam logic [1:0] REG_CHAR_SPACING = 2'd2;

  // ']' introduces a colour byte
  localparam logic [7:0] CHAR_COLOUR_ESC = 8'h5D;

  typedef struct packed {
    logic        [1:0]  action;
    logic        [5:0]  glyph_index;
    logic        [3:0]  stroke_index;
    logic        [4:0]  stroke_total;
    logic signed [7:0]  stroke_x0;
    logic signed [7:0]  stroke_y0;
    logic signed [7:0]  stroke_x1;
    logic signed [7:0]  stroke_y1;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic        [7:0]  start_color;
    logic        [7:0]  char_code;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] line_x0;
    logic signed [15:0] line_y0;
    logic signed [15:0] line_x1;
    logic signed [15:0] line_y1;
    logic        [7:0]  line_color;
    logic               last_line;
  } out_beat_t;

  typedef struct packed {
    logic signed [7:0] scale_x;
    logic signed [7:0] scale_y;
    logic signed [7:0] char_spacing;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic lookup;  // glyph count read issued
    logic count;   // glyph count read data present
    logic emit;    // stroke lines being produced
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic draw_req;     // offered beat is a drawable character
    logic cnt_zero;     // glyph has no strokes
    logic out_free;     // output register can take a line
    logic last_stroke;  // current stroke is the glyph's last
  } dp_sts_t;

  // Character to glyph: {mapped, glyph}
  function automatic logic [6:0] glyph_map(input logic [7:0] c);
    logic [6:0] g;
    g = '0;
    case (c) inside
      [8'd65:8'd90]: g = {1'b1, 6'(c - 8'd65)};          // 'A'..'Z'
      [8'd48:8'd57]: g = {1'b1, 6'(c - 8'd48 + 8'd26)};  // '0'..'9'
      8'd46:         g = {1'b1, 6'd36};                  // '.'
      8'd44:         g = {1'b1, 6'd37};                  // ','
      8'd45:         g = {1'b1, 6'd38};                  // '-'
      8'd63:         g = {1'b1, 6'd39};                  // '?'
      8'd33:         g = {1'b1, 6'd40};                  // '!'
      8'd58:         g = {1'b1, 6'd41};                  // ':'
      8'd59:         g = {1'b1, 6'd42};                  // ';'
      8'd116:        g = {1'b1, 6'd43};                  // 't'
      8'd43:         g = {1'b1, 6'd44};                  // '+'
      8'd120:        g = {1'b1, 6'd45};                  // 'x'
      8'd39:         g = {1'b1, 6'd46};                  // apostrophe
      default:       g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vtsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vtsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vtsg_ctrl.sv =====
// Sequencing state machine of the stroke generator.
`default_nettype none

module vtsg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire vtsg_pkg::dp_sts_t sts_i,
  output      vtsg_pkg::dp_cmd_t cmd_o,
  output      logic              in_stall_o
);

  import vtsg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_COUNT  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.draw_req) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (sts_i.cnt_zero) state_d = ST_IDLE;
        else                state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.last_stroke) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.lookup = (state_q == ST_LOOKUP);
  assign cmd_o.count  = (state_q == ST_COUNT);
  assign cmd_o.emit   = (state_q == ST_EMIT);
  assign in_stall_o   = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/vtsg_dp.sv =====
// Datapath: glyph stores, pen state, stroke scaling and the output register.
`default_nettype none

module vtsg_dp #(
  parameter int GLYPH_COUNT = vtsg_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_STROKES = vtsg_pkg::MAX_STROKES_DEF,
  parameter int COORD_BITS  = vtsg_pkg::COORD_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vtsg_pkg::in_beat_t  in_beat_i,
  input  wire vtsg_pkg::cfg_t      cfg_i,
  input  wire vtsg_pkg::dp_cmd_t   cmd_i,
  output      vtsg_pkg::dp_sts_t   sts_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      vtsg_pkg::out_beat_t out_beat_o
);

  import vtsg_pkg::*;

  localparam int GLYPH_W  = $clog2(GLYPH_COUNT);
  localparam int SA_DEPTH = GLYPH_COUNT * MAX_STROKES;
  localparam int SA_W     = $clog2(SA_DEPTH);
  localparam int CNT_W    = $clog2(MAX_STROKES + 1);
  localparam int IDX_W    = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
  localparam int SUM_W    = (COORD_BITS > 15) ? COORD_BITS + 3 : 18;

  localparam logic signed [SUM_W-1:0] C_HI =
    SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] C_LO =
    SUM_W'(-(64'sd1 <<< (COORD_BITS - 1)));

  function automatic logic signed [COORD_BITS-1:0] sat_c(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v > C_HI)      r = COORD_BITS'(C_HI);
    else if (v < C_LO) r = COORD_BITS'(C_LO);
    else               r = COORD_BITS'(v);
    return r;
  endfunction

  // ---- decode of the offered beat
  logic [6:0] map_w;
  logic       is_load, is_begin, is_char, is_esc;
  logic       load_ok, draw_w;

  assign map_w    = glyph_map(in_beat_i.char_code);
  assign is_load  = (in_beat_i.action == ACT_LOAD);
  assign is_begin = (in_beat_i.action == ACT_BEGIN);
  assign is_char  = (in_beat_i.action == ACT_CHAR);
  assign is_esc   = (in_beat_i.char_code == CHAR_COLOUR_ESC);
  assign load_ok  = is_load && (int'(in_beat_i.glyph_index) < GLYPH_COUNT);

  // ---- pen, colour and escape state
  logic signed [COORD_BITS-1:0] pen_x_q, pen_y_q;
  logic [7:0]                   color_q;
  logic                         expect_q;

  assign draw_w = is_char && !expect_q && !is_esc && map_w[6];

  // scale-derived offsets; halves truncate toward zero
  logic signed [9:0]  sx3, sx3_rnd, sx3_half;
  logic signed [10:0] sy5, sy5_rnd, sy5_half;
  logic signed [SUM_W-1:0] pen_x_ext, pen_adv, cx_d, cy_d;

  assign sx3      = 10'(cfg_i.scale_x) + (10'(cfg_i.scale_x) <<< 1);
  assign sx3_rnd  = sx3 + $signed({9'd0, sx3[9]});
  assign sx3_half = sx3_rnd >>> 1;
  assign sy5      = 11'(cfg_i.scale_y) + (11'(cfg_i.scale_y) <<< 2);
  assign sy5_rnd  = sy5 + $signed({10'd0, sy5[10]});
  assign sy5_half = sy5_rnd >>> 1;

  assign pen_x_ext = SUM_W'(pen_x_q);
  assign pen_adv   = pen_x_ext + SUM_W'(sx3) + SUM_W'(cfg_i.char_spacing);
  assign cx_d      = pen_x_ext + SUM_W'(sx3_half);
  assign cy_d      = SUM_W'(pen_y_q) + SUM_W'(sy5_half);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      color_q  <= '0;
      expect_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (is_begin) begin
        pen_x_q  <= sat_c(SUM_W'($signed(in_beat_i.start_x)));
        pen_y_q  <= sat_c(SUM_W'($signed(in_beat_i.start_y)));
        color_q  <= in_beat_i.start_color;
        expect_q <= 1'b0;
      end else if (is_char) begin
        if (expect_q) begin
          color_q  <= in_beat_i.char_code;
          expect_q <= 1'b0;
        end else if (is_esc) begin
          expect_q <= 1'b1;
        end else begin
          pen_x_q <= sat_c(pen_adv);
        end
      end
    end
  end

  // ---- glyph stroke counts: RAM plus per-glyph valid flags
  logic [GLYPH_COUNT-1:0] cnt_vld_q;
  logic [CNT_W-1:0]       cnt_wdata, cnt_rdata, cnt_raw, cnt_eff;
  logic [GLYPH_W-1:0]     glyph_q;

  assign cnt_wdata = (int'(in_beat_i.stroke_total) > MAX_STROKES) ?
                     CNT_W'(MAX_STROKES) : CNT_W'(in_beat_i.stroke_total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.accept && load_ok) begin
      cnt_vld_q[GLYPH_W'(in_beat_i.glyph_index)] <= 1'b1;
    end
  end

  vtsg_ram #(
    .WIDTH (CNT_W),
    .DEPTH (GLYPH_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && load_ok),
    .waddr_i (GLYPH_W'(in_beat_i.glyph_index)),
    .wdata_i (cnt_wdata),
    .raddr_i (glyph_q),
    .rdata_o (cnt_rdata)
  );

  assign cnt_raw = cnt_vld_q[glyph_q] ? cnt_rdata : '0;
  assign cnt_eff = (int'(cnt_raw) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : cnt_raw;

  // ---- stroke store
  logic [SA_W-1:0]  base_q, st_waddr, st_raddr;
  logic             st_we;
  logic [31:0]      st_wdata, st_rdata;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q;
  logic             last_w, out_free_w, load_w;

  assign st_we    = cmd_i.accept && load_ok
                 && (int'(in_beat_i.stroke_index) < MAX_STROKES);
  assign st_waddr = SA_W'(int'(in_beat_i.glyph_index) * MAX_STROKES
                        + int'(in_beat_i.stroke_index));
  assign st_wdata = {in_beat_i.stroke_y1, in_beat_i.stroke_x1,
                     in_beat_i.stroke_y0, in_beat_i.stroke_x0};

  // read address runs one stroke ahead so data lines up with idx_q
  assign st_raddr = base_q + SA_W'(idx_d);

  vtsg_ram #(
    .WIDTH (32),
    .DEPTH (SA_DEPTH)
  ) u_stroke_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign last_w     = (int'(idx_q) + 1 == int'(cnt_q));
  assign out_free_w = !out_valid_o || !out_stall_i;
  assign load_w     = cmd_i.emit && out_free_w;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.count) begin
      idx_d = '0;
    end else if (load_w && !last_w) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // character context, captured at the accept
  logic signed [SUM_W-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && draw_w) begin
      glyph_q <= GLYPH_W'(map_w[5:0]);
      cx_q    <= cx_d;
      cy_q    <= cy_d;
    end
    if (cmd_i.lookup) base_q <= SA_W'(int'(glyph_q) * MAX_STROKES);
    if (cmd_i.count)  cnt_q  <= cnt_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // ---- scaling of the current stroke
  logic signed [8:0]  ny;
  logic signed [15:0] p_x0, p_x1;
  logic signed [16:0] p_y0, p_y1;
  out_beat_t          out_d;

  assign ny   = -(9'(cfg_i.scale_y));
  assign p_x0 = $signed(st_rdata[7:0])   * cfg_i.scale_x;
  assign p_y0 = $signed(st_rdata[15:8])  * ny;
  assign p_x1 = $signed(st_rdata[23:16]) * cfg_i.scale_x;
  assign p_y1 = $signed(st_rdata[31:24]) * ny;

  assign out_d.line_x0    = LINE_W'(sat_c(cx_q + SUM_W'(p_x0)));
  assign out_d.line_y0    = LINE_W'(sat_c(cy_q + SUM_W'(p_y0)));
  assign out_d.line_x1    = LINE_W'(sat_c(cx_q + SUM_W'(p_x1)));
  assign out_d.line_y1    = LINE_W'(sat_c(cy_q + SUM_W'(p_y1)));
  assign out_d.line_color = color_q;
  assign out_d.last_line  = last_w;

  // ---- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_w) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) out_beat_o <= out_d;
  end

  assign sts_o.draw_req    = draw_w;
  assign sts_o.cnt_zero    = (cnt_eff == '0);
  assign sts_o.out_free    = out_free_w;
  assign sts_o.last_stroke = last_w;

endmodule

`default_nettype wire

// ===== hw/rtl/vector_text_stroke_generator_core.sv =====
// Vector text stroke generator top level: register port, controller and datapath.
// Stroke loads, string begins, colour bytes and unmapped characters are taken without stalling the input.
// A drawn character holds the input through the lookup and count states and, if it has strokes,
// the emit state, which gives one line per cycle from the stroke RAM while the output is not stalled.
// Reset clears pen, colour, escape flag, glyph count flags and registers; no clearing pass.
`default_nettype none

module vector_text_stroke_generator_core #(
  parameter int GLYPH_COUNT = vtsg_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_STROKES = vtsg_pkg::MAX_STROKES_DEF,
  parameter int COORD_BITS  = vtsg_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vtsg_pkg::CFG_AW-1:0] paddr,
  input  wire logic [vtsg_pkg::CFG_DW-1:0] pwdata,
  output      logic [vtsg_pkg::CFG_DW-1:0] prdata,
  output      logic                        pready,
  // input beats
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire vtsg_pkg::in_beat_t          in_beat_i,
  // line beats
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      vtsg_pkg::out_beat_t         out_beat_o
);

  import vtsg_pkg::*;

  // ------------------------------------------------------------------
  // Registers. Word addressed; byte offset bits ignored. Writes must only
  // happen while idle; the block does not enforce it or hold the datapath.
  // ------------------------------------------------------------------
  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       reg_wr;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_x      <= 8'sd1;
      cfg_q.scale_y      <= 8'sd1;
      cfg_q.char_spacing <= 8'sd0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_SCALE_X:      cfg_q.scale_x      <= pwdata[7:0];
        REG_SCALE_Y:      cfg_q.scale_y      <= pwdata[7:0];
        REG_CHAR_SPACING: cfg_q.char_spacing <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE_X:      prdata = {24'd0, cfg_q.scale_x};
      REG_SCALE_Y:      prdata = {24'd0, cfg_q.scale_y};
      REG_CHAR_SPACING: prdata = {24'd0, cfg_q.char_spacing};
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Controller: idle -> count lookup -> count check -> one line per
  // cycle while the output register can take it. The input is only
  // taken in idle; the output register decouples the line side so a
  // new beat can be taken while the last line still waits.
  // ------------------------------------------------------------------
  dp_cmd_t cmd;
  dp_sts_t sts;

  vtsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // ------------------------------------------------------------------
  // Datapath: glyph count RAM with valid flags, stroke RAM, pen state,
  // four multipliers (two 8x8, two 8x9) and saturation, output register.
  // ------------------------------------------------------------------
  vtsg_dp #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .MAX_STROKES (MAX_STROKES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vtsg_checker.sv =====
// Port-level checker of the stroke generator, bound to the top level.
`default_nettype none
`include "vector_text_stroke_generator_core_macros.svh"

module vtsg_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire vtsg_pkg::out_beat_t out_beat_o
);

  import vtsg_pkg::*;

  // a stalled line beat holds
  `VTSG_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat_o), "line beat changed under stall")

  // new lines only come while a character is being drawn
  `VTSG_ASSERT_IMP(a_out_from_busy, $rose(out_valid_o), $past(in_stall_o), "line beat appeared while idle")

  // lines of a character remain to come, so the input stays held
  `VTSG_ASSERT_IMP(a_busy_mid_char, out_valid_o && !out_beat_o.last_line, in_stall_o, "input taken mid character")

  // the next line of a character follows at once in the same colour
  `VTSG_ASSERT_NXT(a_colour_run, out_valid_o && !out_stall_i && !out_beat_o.last_line, out_valid_o && (out_beat_o.line_color == $past(out_beat_o.line_color)), "line colour broke within a character")

endmodule

bind vector_text_stroke_generator_core vtsg_checker u_checker (.*);

`default_nettype wire
